>>> design/lsq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared opcodes and sequencer state codes of the linear-scan priority queue.
// ----------------------------------------------------------------------------
package lsq_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   localparam int PRIO_W  = 32;
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 5;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ADD   = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

endpackage
`default_nettype wire

>>> design/lsq_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsq_mem
// Slot storage for priority and tag: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lsq_mem #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [IW-1:0]                     wr_addr,
   input  wire logic signed [lsq_pkg::PRIO_W-1:0] wr_prio,
   input  wire logic [lsq_pkg::TAG_W-1:0]         wr_tag,
   input  wire logic                              rd_en,
   input  wire logic [IW-1:0]                     rd_addr,
   output logic signed [lsq_pkg::PRIO_W-1:0]      rd_prio,
   output logic [lsq_pkg::TAG_W-1:0]              rd_tag
);

   logic [lsq_pkg::PRIO_W+lsq_pkg::TAG_W-1:0] mem_array [DEPTH];
   logic [lsq_pkg::PRIO_W+lsq_pkg::TAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= {wr_prio, wr_tag};
      end
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_prio = $signed(rd_data_ff[lsq_pkg::PRIO_W+lsq_pkg::TAG_W-1:lsq_pkg::TAG_W]);
   assign rd_tag  = rd_data_ff[lsq_pkg::TAG_W-1:0];

endmodule
`default_nettype wire

>>> design/lsq_best.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsq_best
// Shared compare unit: keeps the best candidate seen during a slot scan.
// ----------------------------------------------------------------------------
module lsq_best #(
   parameter int IW = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              cand_en,
   input  wire logic signed [lsq_pkg::PRIO_W-1:0] cand_prio,
   input  wire logic [lsq_pkg::TAG_W-1:0]         cand_tag,
   input  wire logic [IW-1:0]                     cand_idx,
   output logic                                   found,
   output logic [lsq_pkg::TAG_W-1:0]              best_tag,
   output logic [IW-1:0]                          best_idx
);

   logic                              found_ff, found_in;
   logic signed [lsq_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic [lsq_pkg::TAG_W-1:0]         tag_ff, tag_in;
   logic [IW-1:0]                     idx_ff, idx_in;

   always_comb begin
      found_in = found_ff;
      prio_in  = prio_ff;
      tag_in   = tag_ff;
      idx_in   = idx_ff;
      if (start) begin
         found_in = 1'b0;
      end else if (cand_en && (!found_ff || (cand_prio > prio_ff))) begin
         // strict compare: on a tie the earlier (lower) slot stays
         found_in = 1'b1;
         prio_in  = cand_prio;
         tag_in   = cand_tag;
         idx_in   = cand_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
      idx_ff  <= idx_in;
   end

   assign found    = found_ff;
   assign best_tag = tag_ff;
   assign best_idx = idx_ff;

endmodule
`default_nettype wire

>>> design/linear_scan_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_scan_priority_queue
// Fixed-capacity max-priority queue with add, remove-highest and peek-highest.
// ----------------------------------------------------------------------------
// One request is taken at a time and answers with one result beat. Add walks
// the valid bits one slot per cycle to the lowest free slot, or skips to the
// result when the queue is full. Remove and peek read every slot through the
// single read port of the slot memory and feed one shared comparator, or skip
// to the result when the queue is empty. The highest signed priority wins, the
// lowest slot on a tie. The result waits in an output register, so the next
// request is taken once that register has been loaded.
module linear_scan_priority_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_opcode,
   input  wire logic signed [lsq_pkg::PRIO_W-1:0] req_prio,
   input  wire logic [lsq_pkg::TAG_W-1:0]         req_tag_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_ok,
   output logic [lsq_pkg::TAG_W-1:0]              rsp_tag_out,
   output logic [lsq_pkg::COUNT_W-1:0]            rsp_count,
   output logic                                   rsp_empty_res
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lsq_pkg::state_type state_ff, state_in;

   logic [IW-1:0]                     ptr_ff, ptr_in;
   logic [1:0]                        op_ff;
   logic signed [lsq_pkg::PRIO_W-1:0] prio_ff;
   logic [lsq_pkg::TAG_W-1:0]         tag_ff;
   logic [DEPTH-1:0]                  valid_ff, valid_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic                              add_ok_ff, add_ok_in;
   logic                              cand_on_ff, cand_on_in;
   logic                              cand_vld_ff, cand_vld_in;
   logic [IW-1:0]                     cand_idx_ff, cand_idx_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_ok_ff, rsp_ok_in;
   logic [lsq_pkg::TAG_W-1:0]         rsp_tag_ff, rsp_tag_in;
   logic [lsq_pkg::COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                              rsp_empty_ff, rsp_empty_in;

   logic                              accept;
   logic                              out_free;
   logic                              mem_wr;
   logic                              mem_rd;
   logic                              best_start;

   logic signed [lsq_pkg::PRIO_W-1:0] rd_prio;
   logic [lsq_pkg::TAG_W-1:0]         rd_tag;
   logic                              best_found;
   logic [lsq_pkg::TAG_W-1:0]         best_tag;
   logic [IW-1:0]                     best_idx;

   lsq_mem #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (ptr_ff),
      .wr_prio (prio_ff),
      .wr_tag  (tag_ff),
      .rd_en   (mem_rd),
      .rd_addr (ptr_ff),
      .rd_prio (rd_prio),
      .rd_tag  (rd_tag)
   );

   lsq_best #(
      .IW (IW)
   ) u_best (
      .clock     (clock),
      .reset     (reset),
      .start     (best_start),
      .cand_en   (cand_on_ff && cand_vld_ff),
      .cand_prio (rd_prio),
      .cand_tag  (rd_tag),
      .cand_idx  (cand_idx_ff),
      .found     (best_found),
      .best_tag  (best_tag),
      .best_idx  (best_idx)
   );

   assign req_stall = (state_ff != lsq_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      add_ok_in    = add_ok_ff;
      cand_on_in   = 1'b0;
      cand_vld_in  = cand_vld_ff;
      cand_idx_in  = cand_idx_ff;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      best_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         lsq_pkg::ST_IDLE: begin
            if (accept) begin
               ptr_in     = '0;
               add_ok_in  = 1'b0;
               best_start = 1'b1;
               if (req_opcode == lsq_pkg::OP_ADD) begin
                  state_in = (count_ff == CW'(DEPTH)) ? lsq_pkg::ST_RESP : lsq_pkg::ST_ADD;
               end else if (req_opcode inside {lsq_pkg::OP_REMOVE, lsq_pkg::OP_PEEK}) begin
                  state_in = (count_ff == '0) ? lsq_pkg::ST_RESP : lsq_pkg::ST_SCAN;
               end else begin
                  state_in = lsq_pkg::ST_RESP;
               end
            end
         end
         lsq_pkg::ST_ADD: begin
            // not full, so a free slot turns up before the end
            if (!valid_ff[ptr_ff]) begin
               mem_wr           = 1'b1;
               valid_in[ptr_ff] = 1'b1;
               count_in         = count_ff + 1'b1;
               add_ok_in        = 1'b1;
               state_in         = lsq_pkg::ST_RESP;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         lsq_pkg::ST_SCAN: begin
            // issue one slot read; its valid bit rides along to meet the data
            mem_rd      = 1'b1;
            cand_on_in  = 1'b1;
            cand_vld_in = valid_ff[ptr_ff];
            cand_idx_in = ptr_ff;
            if (ptr_ff == IW'(DEPTH - 1)) begin
               state_in = lsq_pkg::ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         lsq_pkg::ST_DRAIN: begin
            state_in = lsq_pkg::ST_RESP;
         end
         lsq_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_tag_in   = '0;
               if (op_ff == lsq_pkg::OP_ADD) begin
                  rsp_ok_in = add_ok_ff;
               end else if (op_ff inside {lsq_pkg::OP_REMOVE, lsq_pkg::OP_PEEK}) begin
                  rsp_ok_in = best_found;
                  if (best_found) begin
                     rsp_tag_in = best_tag;
                  end
                  if (best_found && (op_ff == lsq_pkg::OP_REMOVE)) begin
                     valid_in[best_idx] = 1'b0;
                     count_in           = count_ff - 1'b1;
                  end
               end
               rsp_empty_in = (count_in == '0);
               // count wraps to the result field width
               rsp_count_in = lsq_pkg::COUNT_W'(count_in);
               state_in     = lsq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsq_pkg::ST_IDLE;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         count_ff     <= '0;
         add_ok_ff    <= 1'b0;
         cand_on_ff   <= 1'b0;
         cand_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         add_ok_ff    <= add_ok_in;
         cand_on_ff   <= cand_on_in;
         cand_vld_ff  <= cand_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         op_ff   <= req_opcode;
         prio_ff <= req_prio;
         tag_ff  <= req_tag_in;
      end
      cand_idx_ff  <= cand_idx_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_tag_out   = rsp_tag_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;

endmodule
`default_nettype wire
